FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the base32 encoder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define B32E_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("b32e assertion failed");

// Next-cycle implication, disabled during reset
`define B32E_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("b32e assertion failed");

`endif

FILE: design/b32e_pkg.sv
// Package for the base32 byte encoder: job type, queue depth, alphabet lookup.
// No dependencies.
`default_nettype none

package b32e_pkg;

    localparam int QUEUE_DEPTH = 2;

    // One classified byte: up to three 5-bit groups, MSB group at [14:10]
    typedef struct packed {
        logic [14:0] window;
        logic [1:0]  num_sym;
        logic        last;
    } b32e_job_t;

    // 5-bit group to ASCII code
    function automatic logic [7:0] b32e_alpha(input logic [4:0] grp);
        logic [7:0] code;
        case (grp)
            5'd0:    code = 8'h41; // A
            5'd1:    code = 8'h42;
            5'd2:    code = 8'h43;
            5'd3:    code = 8'h44;
            5'd4:    code = 8'h45;
            5'd5:    code = 8'h46;
            5'd6:    code = 8'h47;
            5'd7:    code = 8'h48; // H
            5'd8:    code = 8'h4A; // J
            5'd9:    code = 8'h4B; // K
            5'd10:   code = 8'h4D; // M
            5'd11:   code = 8'h4E; // N
            5'd12:   code = 8'h50; // P
            5'd13:   code = 8'h51;
            5'd14:   code = 8'h52;
            5'd15:   code = 8'h53; // S
            5'd16:   code = 8'h54; // T
            5'd17:   code = 8'h56; // V
            5'd18:   code = 8'h57;
            5'd19:   code = 8'h58;
            5'd20:   code = 8'h59;
            5'd21:   code = 8'h5A; // Z
            5'd22:   code = 8'h32; // 2
            5'd23:   code = 8'h33;
            5'd24:   code = 8'h34;
            5'd25:   code = 8'h35;
            5'd26:   code = 8'h36;
            5'd27:   code = 8'h37;
            5'd28:   code = 8'h38;
            5'd29:   code = 8'h39; // 9
            5'd30:   code = 8'h30; // 0
            5'd31:   code = 8'h31; // 1
            default: code = 8'h41;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: design/b32e_front.sv
// Front end: accepts bytes, merges them with leftover bits, builds jobs.
// Depends on b32e_pkg.
`default_nettype none

module b32e_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_ready,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_byte,
    output logic                     job_valid,
    input  wire logic                job_ready,
    output b32e_pkg::b32e_job_t      job
);
    import b32e_pkg::*;

    logic [3:0]  leftover_bits_reg, leftover_bits_next;
    logic [2:0]  leftover_count_reg, leftover_count_next;
    logic [3:0]  lo_mask;
    logic [3:0]  rem_mask;
    logic [11:0] acc;
    logic [3:0]  bits;
    logic [3:0]  shift;
    logic        two_full;
    logic [2:0]  rem;
    logic        push;

    assign byte_ready = job_ready;
    assign job_valid  = byte_valid;
    assign push       = byte_valid && job_ready;

    // Merge pending bits above the new byte
    always_comb
    begin
        lo_mask  = 4'((5'd1 << leftover_count_reg) - 5'd1);
        acc      = {leftover_bits_reg & lo_mask, data_byte};
        bits     = {1'b0, leftover_count_reg} + 4'd8;
        two_full = (bits >= 4'd10);
        rem      = two_full ? 3'(bits - 4'd10) : 3'(bits - 4'd5);
        rem_mask = 4'((5'd1 << rem) - 5'd1);
        shift    = 4'd15 - bits;
    end

    // Job: left-aligned window, symbol count, end-of-message flag
    always_comb
    begin
        job.window  = 15'({3'b000, acc} << shift);
        job.num_sym = two_full ? 2'd2 : 2'd1;
        if (last_byte && (rem != 3'd0))
        begin
            job.num_sym = job.num_sym + 2'd1;
        end
        job.last = last_byte;
    end

    // Leftover update
    always_comb
    begin
        leftover_bits_next  = leftover_bits_reg;
        leftover_count_next = leftover_count_reg;
        if (push)
        begin
            if (last_byte)
            begin
                leftover_bits_next  = 4'd0;
                leftover_count_next = 3'd0;
            end
            else
            begin
                leftover_bits_next  = acc[3:0] & rem_mask;
                leftover_count_next = rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= 4'd0;
            leftover_count_reg <= 3'd0;
        end
        else
        begin
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/b32e_fifo.sv
// Job queue between the front end and the symbol emitter.
// Depends on b32e_pkg.
`default_nettype none

module b32e_fifo #(
    parameter int DEPTH = b32e_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_valid,
    output logic                     wr_ready,
    input  wire b32e_pkg::b32e_job_t wr_job,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output b32e_pkg::b32e_job_t      rd_job
);
    import b32e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b32e_job_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

FILE: design/b32e_back.sv
// Back end: steps through the groups of each job, one symbol per cycle while a job waits and sym_ready is high.
// Depends on b32e_pkg.
`default_nettype none

module b32e_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                job_valid,
    output logic                     job_ready,
    input  wire b32e_pkg::b32e_job_t job,
    output logic                     sym_valid,
    input  wire logic                sym_ready,
    output logic [7:0]               symbol_code,
    output logic                     last_symbol
);
    import b32e_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] code_reg, code_next;
    logic       last_reg, last_next;
    logic       load;
    logic       final_grp;
    logic [4:0] grp;

    assign sym_valid   = out_valid_reg;
    assign symbol_code = code_reg;
    assign last_symbol = last_reg;

    assign load      = job_valid && (!out_valid_reg || sym_ready);
    assign final_grp = (idx_reg == (job.num_sym - 2'd1));
    assign job_ready = load && final_grp;

    // Group select
    always_comb
    begin
        case (idx_reg)
            2'd0:    grp = job.window[14:10];
            2'd1:    grp = job.window[9:5];
            2'd2:    grp = job.window[4:0];
            default: grp = job.window[4:0];
        endcase
    end

    // Output register and group counter
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            code_next      = b32e_alpha(grp);
            last_next      = job.last && final_grp;
            idx_next       = final_grp ? 2'd0 : idx_reg + 2'd1;
        end
        else if (sym_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

FILE: design/base32_byte_encoder.sv
// Base32 byte encoder top level: front end, job queue, symbol emitter.
// An accepted byte's first symbol reaches the output register via the queue.
// One symbol per cycle leaves the output register while jobs are queued and
// sym_ready is high; a byte yields one to three symbols, about 1.6 on average.
// Reset (rst_n, async, active low) clears leftover bits, queue and output.
// Depends on b32e_pkg, b32e_front, b32e_fifo, b32e_back.
`default_nettype none

module base32_byte_encoder #(
    parameter int QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            sym_valid,
    input  wire logic       sym_ready,
    output logic [7:0]      symbol_code,
    output logic            last_symbol
);
    import b32e_pkg::*;

    b32e_job_t fr_job;
    b32e_job_t bk_job;
    logic      fr_valid;
    logic      fr_ready;
    logic      bk_valid;
    logic      bk_ready;

    b32e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .job_valid  (fr_valid),
        .job_ready  (fr_ready),
        .job        (fr_job)
    );

    b32e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_job   (fr_job),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_job   (bk_job)
    );

    b32e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (bk_valid),
        .job_ready   (bk_ready),
        .job         (bk_job),
        .sym_valid   (sym_valid),
        .sym_ready   (sym_ready),
        .symbol_code (symbol_code),
        .last_symbol (last_symbol)
    );

endmodule

`default_nettype wire

FILE: design/b32e_checker.sv
// Port-level checker for the base32 byte encoder, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module b32e_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       sym_valid,
    input wire logic       sym_ready,
    input wire logic [7:0] symbol_code,
    input wire logic       last_symbol
);

    // Stalled output transaction holds
    `B32E_ASSERT_NEXT(a_out_hold, clk, rst_n, sym_valid && !sym_ready, sym_valid && $stable(symbol_code) && $stable(last_symbol))

    // Excluded letters never appear
    `B32E_ASSERT_NOW(a_no_excluded, clk, rst_n, sym_valid, symbol_code != 8'h49 && symbol_code != 8'h4C && symbol_code != 8'h4F && symbol_code != 8'h55)

    // Every code is an upper-case letter or a digit
    `B32E_ASSERT_NOW(a_code_range, clk, rst_n, sym_valid, (symbol_code >= 8'h41 && symbol_code <= 8'h5A) || (symbol_code >= 8'h30 && symbol_code <= 8'h39))

endmodule

bind base32_byte_encoder b32e_checker u_b32e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .sym_valid   (sym_valid),
    .sym_ready   (sym_ready),
    .symbol_code (symbol_code),
    .last_symbol (last_symbol)
);

`default_nettype wire
